### sv/wmb_pkg.sv
// Package for the weighted mean binner.
// Register indexes, field widths and default parameter values.
`default_nettype none
package wmb_pkg;
  localparam int CFG_W          = 16;
  localparam int CFG_IDX_W      = 1;
  localparam int DATA_W         = 32;
  localparam int ACC_W          = 64;
  localparam int COUNT_BITS_DEF = 16;

  localparam logic [CFG_IDX_W-1:0] REG_BIN_SIZE      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHTED_MODE = 1'd1;
endpackage
`default_nettype wire

### sv/weighted_mean_binner.sv
// Weighted mean binner: groups samples into bins, emits plain or inverse-variance mean.
// Uses wmb_pkg. One shared restoring divide / square root unit under a small sequencer.
//
//  channel | signals                                   | direction
//  in      | in_valid, in_stall, sample, uncertainty   | into block
//  out     | out_valid, out_stall, bin_mean,           | out of block
//          | bin_deviation, bad_bin                    |
//  cfg     | cfg_we, cfg_index, cfg_data               | into block
//
// Plain sample: added to the total on entry. Weighted sample: waits for the 65-step reciprocal.
// Bin end adds 64 steps (plain) or 96 + 65 + 32 steps (weighted) in the same unit.
// rst is synchronous; it clears the accumulators and sets bin_size 1, plain mode.
// Input is taken only while the sequencer is idle; a finished result waits in the
// output register while the next item is taken.
`default_nettype none
module weighted_mean_binner #(
  parameter int COUNT_BITS = wmb_pkg::COUNT_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [wmb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [wmb_pkg::CFG_W-1:0]       cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic signed [wmb_pkg::DATA_W-1:0] sample,
  input  wire logic [wmb_pkg::DATA_W-1:0]      uncertainty,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic signed [wmb_pkg::DATA_W-1:0]    bin_mean,
  output logic [wmb_pkg::DATA_W-1:0]           bin_deviation,
  output logic                                 bad_bin
);
  import wmb_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RECIPW = 4'd1;
  localparam logic [3:0] S_MUL1   = 4'd2;
  localparam logic [3:0] S_MUL2   = 4'd3;
  localparam logic [3:0] S_ACC    = 4'd4;
  localparam logic [3:0] S_COUNT  = 4'd5;
  localparam logic [3:0] S_MDIV   = 4'd6;
  localparam logic [3:0] S_DRECIP = 4'd7;
  localparam logic [3:0] S_SQRT   = 4'd8;
  localparam logic [3:0] S_FIN    = 4'd9;

  localparam int CMPW = (COUNT_BITS > CFG_W ? COUNT_BITS : CFG_W) + 1;
  localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};
  localparam logic [ACC_W-1:0] ONES = {ACC_W{1'b1}};

  logic [3:0] state;
  logic [CFG_W-1:0] bin_size;
  logic weighted_mode;
  logic [ACC_W-1:0] weight_total;
  logic signed [ACC_W-1:0] value_total;
  logic [COUNT_BITS-1:0] samples_in_bin;
  logic zero_seen;

  logic [DATA_W-1:0] mag_x;
  logic neg_x;
  logic [ACC_W-1:0] w_reg, p1, p2;
  logic [DATA_W-1:0] res_mean, res_dev;

  // shared divide / sqrt unit
  logic [127:0] dn;
  logic [65:0] dr;
  logic [63:0] dq, dd;
  logic dovf, dsqrt;
  logic [6:0] dsteps;
  logic [65:0] r2, cmpv, diff;
  logic ge, run;

  assign r2   = dsqrt ? {dr[63:0], dn[127:126]} : {dr[64:0], dn[127]};
  assign cmpv = dsqrt ? {dq, 2'b01} : {2'b00, dd};
  assign ge   = r2 >= cmpv;
  assign diff = r2 - cmpv;
  assign run  = (dsteps != 7'd0);

  function automatic logic [DATA_W-1:0] sat_mean(input logic neg, input logic ovf,
                                                 input logic [63:0] q);
    logic [DATA_W-1:0] m;
    begin
      m = '0;
      if (neg) begin
        if (ovf || q > 64'h8000_0000) m = 32'h8000_0000;
        else m = 32'(64'd0 - q);
      end else begin
        if (ovf || q > 64'h7FFF_FFFF) m = 32'h7FFF_FFFF;
        else m = q[31:0];
      end
      return m;
    end
  endfunction

  logic [ACC_W-1:0] xs_ext, term, tsum, vt_mag;
  logic signed [ACC_W:0] vsum;
  logic [ACC_W:0] wsum;
  logic signed [ACC_W-1:0] vt_next, add_val;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [CFG_W-1:0] size_eff;
  logic bin_done, vt_neg;
  logic load_out;

  assign xs_ext  = ACC_W'(sample);
  assign tsum    = p1 + {32'd0, p2[63:32]};
  assign term    = neg_x ? (64'd0 - tsum) : tsum;
  assign add_val = (state == S_IDLE) ? signed'(xs_ext) : signed'(term);
  assign vsum    = {value_total[ACC_W-1], value_total} + {add_val[ACC_W-1], add_val};
  assign vt_next = (vsum[ACC_W] != vsum[ACC_W-1])
                 ? (vsum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}})
                 : vsum[ACC_W-1:0];
  assign wsum    = {1'b0, weight_total} + {1'b0, w_reg};
  assign vt_neg  = value_total[ACC_W-1];
  assign vt_mag  = vt_neg ? (64'd0 - value_total) : value_total;
  assign cnt_inc = (samples_in_bin != CMAX) ? samples_in_bin + 1'b1 : samples_in_bin;
  assign size_eff = (bin_size == '0) ? CFG_W'(1) : bin_size;
  assign bin_done = (CMPW'(cnt_inc) >= CMPW'(size_eff)) || (cnt_inc == CMAX);
  assign load_out = (state == S_FIN) && (!out_valid || !out_stall);

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      bin_size <= CFG_W'(1);
      weighted_mode <= 1'b0;
      weight_total <= '0;
      value_total <= '0;
      samples_in_bin <= '0;
      zero_seen <= 1'b0;
      out_valid <= 1'b0;
      dsteps <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_BIN_SIZE:      bin_size <= cfg_data;
          REG_WEIGHTED_MODE: weighted_mode <= cfg_data[0];
          default: ;
        endcase
      end
      if (load_out) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;

      if (run) begin
        dr <= ge ? diff : r2;
        dn <= dsqrt ? {dn[125:0], 2'b00} : {dn[126:0], 1'b0};
        dq <= {dq[62:0], ge};
        dovf <= dovf | dq[63];
        dsteps <= dsteps - 7'd1;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            mag_x <= sample[DATA_W-1] ? (32'd0 - sample) : sample;
            neg_x <= sample[DATA_W-1];
            if (!weighted_mode) begin
              value_total <= vt_next;
              state <= S_COUNT;
            end else if (uncertainty == '0) begin
              zero_seen <= 1'b1;
              state <= S_COUNT;
            end else begin
              dd <= ACC_W'(uncertainty) * ACC_W'(uncertainty);
              dn <= {1'b1, 127'd0};
              dr <= '0; dq <= '0; dovf <= 1'b0; dsqrt <= 1'b0;
              dsteps <= 7'd65;
              state <= S_RECIPW;
            end
          end
        end
        S_RECIPW: begin
          if (!run) begin
            w_reg <= dovf ? ONES : dq;
            state <= S_MUL1;
          end
        end
        S_MUL1: begin
          p1 <= ACC_W'(mag_x) * ACC_W'(w_reg[63:32]);
          state <= S_MUL2;
        end
        S_MUL2: begin
          p2 <= ACC_W'(mag_x) * ACC_W'(w_reg[31:0]);
          state <= S_ACC;
        end
        S_ACC: begin
          value_total <= vt_next;
          weight_total <= wsum[ACC_W] ? ONES : wsum[ACC_W-1:0];
          state <= S_COUNT;
        end
        S_COUNT: begin
          samples_in_bin <= cnt_inc;
          if (!bin_done) begin
            state <= S_IDLE;
          end else if (zero_seen) begin
            res_mean <= '0; res_dev <= '0;
            state <= S_FIN;
          end else if (weighted_mode && weight_total == '0) begin
            res_mean <= '0; res_dev <= '1;
            state <= S_FIN;
          end else begin
            dr <= '0; dq <= '0; dovf <= 1'b0; dsqrt <= 1'b0;
            if (weighted_mode) begin
              dn <= {vt_mag, 64'd0};
              dd <= weight_total;
              dsteps <= 7'd96;
            end else begin
              dn <= {vt_mag, 64'd0};
              dd <= ACC_W'(cnt_inc);
              dsteps <= 7'd64;
            end
            state <= S_MDIV;
          end
        end
        S_MDIV: begin
          if (!run) begin
            res_mean <= sat_mean(vt_neg, dovf, dq);
            if (weighted_mode) begin
              dn <= {1'b1, 127'd0};
              dr <= '0; dq <= '0; dovf <= 1'b0;
              dd <= weight_total;
              dsteps <= 7'd65;
              state <= S_DRECIP;
            end else begin
              res_dev <= '0;
              state <= S_FIN;
            end
          end
        end
        S_DRECIP: begin
          if (!run) begin
            dn <= {(dovf ? ONES : dq), 64'd0};
            dr <= '0; dq <= '0; dovf <= 1'b0; dsqrt <= 1'b1;
            dsteps <= 7'd32;
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (!run) begin
            res_dev <= dq[31:0];
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (load_out) begin
            bin_mean <= res_mean;
            bin_deviation <= res_dev;
            bad_bin <= zero_seen;
            weight_total <= '0;
            value_total <= '0;
            samples_in_bin <= '0;
            zero_seen <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_idle_unit_quiet: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> dsteps == 7'd0)
    else $error("shared unit busy while idle");
  a_fin_load: assert property (@(posedge clk) disable iff (rst)
    state == S_FIN && !(out_valid && out_stall) |=> out_valid && state == S_IDLE)
    else $error("result not loaded");
  a_count_cleared: assert property (@(posedge clk) disable iff (rst)
    state == S_FIN && !(out_valid && out_stall) |=> samples_in_bin == '0 && !zero_seen)
    else $error("bin state not cleared");
endmodule
`default_nettype wire
